>>> rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types of the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int unsigned TDPT_VALUE_WIDTH   = 32;
    localparam int unsigned TDPT_VERDICT_WIDTH = 2;

    typedef enum logic [TDPT_VERDICT_WIDTH-1:0] {
        VERDICT_PRIME       = 2'd0,
        VERDICT_COMPOSITE   = 2'd1,
        VERDICT_NOT_NATURAL = 2'd2
    } verdict_t;

    // status of one remainder pass
    typedef struct packed {
        logic done;        // one-cycle pulse, flags below are valid
        logic below_root;  // quotient < divisor, so divisor squared exceeds n
        logic divides;     // remainder is zero
    } div_status_t;

endpackage : tdpt_pkg
`default_nettype wire

>>> rtl/tdpt_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_divider
// Bit-serial restoring divider: one dividend bit per cycle while busy, gives
// quotient and remainder flags.
// ----------------------------------------------------------------------------
module tdpt_divider
    import tdpt_pkg::*;
#(
    parameter int unsigned MAG_WIDTH = TDPT_VALUE_WIDTH - 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [MAG_WIDTH-1:0] dividend,
    input  wire logic [MAG_WIDTH-1:0] divisor,
    output div_status_t               status
);

    localparam int unsigned CW = $clog2(MAG_WIDTH);
    localparam logic [CW-1:0] LAST_COUNT = CW'(MAG_WIDTH - 1);

    logic [MAG_WIDTH-1:0] rem_reg, rem_next;
    logic [MAG_WIDTH-1:0] quo_reg;
    logic [MAG_WIDTH-1:0] div_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [MAG_WIDTH:0]   trial;
    logic [MAG_WIDTH:0]   diff;
    logic                 fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[MAG_WIDTH-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
                cnt_reg  <= LAST_COUNT;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[MAG_WIDTH-2:0], fits};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign status.done       = done_reg;
    assign status.below_root = quo_reg < div_reg;
    assign status.divides    = rem_reg == '0;

endmodule : tdpt_divider
`default_nettype wire

>>> rtl/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// A value below 2 goes straight to the result beat; otherwise the unit tries
// trial divisors from 2 up to floor(sqrt(n))+1, each through the bit-serial
// remainder unit (start, one dividend bit per cycle, done). One candidate at
// a time; the next beat is taken in the cycle after the result loads, also
// while it waits at the output.
// Reset (aresetn low, synchronous) empties all.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = TDPT_VALUE_WIDTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // candidate
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // verdict, tested_value
    output logic [((VALUE_WIDTH+TDPT_VERDICT_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned MAG_WIDTH = VALUE_WIDTH - 1;
    localparam logic [MAG_WIDTH-1:0] FIRST_DIVISOR = MAG_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_HOLD
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] cand_reg;
    logic [MAG_WIDTH-1:0]   div_reg;
    verdict_t               verdict_reg;
    logic                   m_valid_reg;
    verdict_t               m_verdict_reg;
    logic [VALUE_WIDTH-1:0] m_value_reg;

    logic                   div_start;
    div_status_t            div_status;
    logic [VALUE_WIDTH-1:0] s_value;
    logic                   out_free;
    logic                   load_out;

    assign s_value   = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready  = state_reg == S_IDLE;
    assign div_start = state_reg == S_START;
    assign out_free  = !m_valid_reg || m_tready;
    assign load_out  = state_reg == S_HOLD && out_free;

    tdpt_divider #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cand_reg[MAG_WIDTH-1:0]),
        .divisor  (div_reg),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cand_reg <= s_value;
                        div_reg  <= FIRST_DIVISOR;
                        if (s_value[VALUE_WIDTH-1] || s_value == '0) begin
                            verdict_reg <= VERDICT_NOT_NATURAL;
                            state_reg   <= S_HOLD;
                        end else if (s_value == ONE) begin
                            verdict_reg <= VERDICT_COMPOSITE;
                            state_reg   <= S_HOLD;
                        end else begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_status.done) begin
                        if (div_status.below_root) begin
                            verdict_reg <= VERDICT_PRIME;
                            state_reg   <= S_HOLD;
                        end else if (div_status.divides) begin
                            verdict_reg <= VERDICT_COMPOSITE;
                            state_reg   <= S_HOLD;
                        end else begin
                            div_reg   <= div_reg + 1'b1;
                            state_reg <= S_START;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        m_verdict_reg <= verdict_reg;
                        m_value_reg   <= cand_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[TDPT_VERDICT_WIDTH-1:0] = m_verdict_reg;
        m_tdata[VALUE_WIDTH+TDPT_VERDICT_WIDTH-1:TDPT_VERDICT_WIDTH] = m_value_reg;
    end

endmodule : trial_division_prime_test_top
`default_nettype wire
